[sv/clook_pkg.sv]
// ----------------------------------------------------------------------------
// clook_pkg
// shared codes and the command/status bundles between controller and datapath
// ----------------------------------------------------------------------------
package clook_pkg;

    // widths fixed by the item fields
    localparam int POS_PORT_W = 48;
    localparam int POS_WIDE_W = 64;

    // item kind codes
    localparam logic KIND_ADD      = 1'b0;
    localparam logic KIND_DISPATCH = 1'b1;

    // result status codes
    localparam logic [1:0] ST_ADDED  = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_SERVED = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    typedef struct packed {
        logic load;    // capture the item and reset the scan
        logic issue;   // read the slot at the scan index and step on
        logic commit;  // apply the outcome and present the result
    } t_dp_cmd;

    typedef struct packed {
        logic last_issue;  // scan index is on the final slot
    } t_dp_sts;

endpackage

[sv/clook_ctrl.sv]
// ----------------------------------------------------------------------------
// clook_ctrl
// sequencer: accept, slot scan, pipeline drain, commit
// ----------------------------------------------------------------------------
module clook_ctrl import clook_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    busy
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.issue  = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            // last slot read lands in the compare stage here
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

[sv/clook_dp.sv]
// ----------------------------------------------------------------------------
// clook_dp
// slot store, head register, one-slot-per-cycle scan and result register
// ----------------------------------------------------------------------------
module clook_dp import clook_pkg::*; #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int POSITION_BITS = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic                  i_kind,
    input  logic [POS_PORT_W-1:0] i_position,
    input  logic                  i_is_write,
    output logic                  o_done,
    output logic [1:0]            o_status,
    output logic [POS_PORT_W-1:0] o_served_position,
    output logic                  o_served_write
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int PW    = POSITION_BITS;

    // slot store: {write flag, position}
    logic [PW:0] mem_slot [QUEUE_DEPTH];

    logic [QUEUE_DEPTH-1:0] r_used;
    logic [PW-1:0]          r_head;

    // captured item
    logic          r_kind;
    logic [PW-1:0] r_pos;
    logic          r_wr;

    // scan read stage
    logic [IDX_W-1:0] r_idx;
    logic             r_rd_vld;
    logic [PW:0]      r_rd_data;
    logic             r_rd_used;
    logic [IDX_W-1:0] r_rd_idx;

    // running picks
    logic             r_abv_found;
    logic [PW-1:0]    r_abv_pos;
    logic             r_abv_wr;
    logic [IDX_W-1:0] r_abv_idx;
    logic             r_low_found;
    logic [PW-1:0]    r_low_pos;
    logic             r_low_wr;
    logic [IDX_W-1:0] r_low_idx;
    logic             r_free_found;
    logic [IDX_W-1:0] r_free_idx;

    // result register
    logic                  r_out_vld;
    logic [1:0]            r_status;
    logic [POS_PORT_W-1:0] r_out_pos;
    logic                  r_out_wr;

    logic [POS_WIDE_W-1:0] w_in_ext;
    logic [PW-1:0]         w_rd_pos;
    logic                  w_rd_wr;
    logic                  w_pick_above;
    logic                  w_pick_low;
    logic [IDX_W-1:0]      w_pick_idx;
    logic [PW-1:0]         w_pick_pos;
    logic                  w_pick_wr;
    logic [POS_WIDE_W-1:0] w_pick_ext;

    assign w_in_ext = POS_WIDE_W'(i_position);
    assign w_rd_pos = r_rd_data[PW-1:0];
    assign w_rd_wr  = r_rd_data[PW];

    // c-look: nearest strictly above the head, lowest slot wins ties
    assign w_pick_above = r_rd_used && (w_rd_pos > r_head) &&
                          (!r_abv_found || (w_rd_pos < r_abv_pos));
    assign w_pick_low   = r_rd_used && (!r_low_found || (w_rd_pos < r_low_pos));

    assign w_pick_idx = r_abv_found ? r_abv_idx : r_low_idx;
    assign w_pick_pos = r_abv_found ? r_abv_pos : r_low_pos;
    assign w_pick_wr  = r_abv_found ? r_abv_wr  : r_low_wr;
    assign w_pick_ext = POS_WIDE_W'(w_pick_pos);

    assign o_sts.last_issue = (r_idx == IDX_W'(QUEUE_DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_rd_data <= mem_slot[r_idx];
        end
        if (i_cmd.commit && (r_kind == KIND_ADD) && r_free_found) begin
            mem_slot[r_free_idx] <= {r_wr, r_pos};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_pos  <= w_in_ext[PW-1:0];
            r_wr   <= i_is_write;
        end
        if (i_cmd.issue) begin
            r_rd_used <= r_used[r_idx];
            r_rd_idx  <= r_idx;
        end
        if (r_rd_vld && (r_kind == KIND_DISPATCH)) begin
            if (w_pick_above) begin
                r_abv_pos <= w_rd_pos;
                r_abv_wr  <= w_rd_wr;
                r_abv_idx <= r_rd_idx;
            end
            if (w_pick_low) begin
                r_low_pos <= w_rd_pos;
                r_low_wr  <= w_rd_wr;
                r_low_idx <= r_rd_idx;
            end
        end
        if (r_rd_vld && (r_kind == KIND_ADD) && !r_rd_used && !r_free_found) begin
            r_free_idx <= r_rd_idx;
        end
        if (i_cmd.commit) begin
            r_out_pos <= '0;
            r_out_wr  <= 1'b0;
            if (r_kind == KIND_ADD) begin
                r_status <= r_free_found ? ST_ADDED : ST_FULL;
            end else if (r_low_found) begin
                r_status  <= ST_SERVED;
                r_out_pos <= w_pick_ext[POS_PORT_W-1:0];
                r_out_wr  <= w_pick_wr;
            end else begin
                r_status <= ST_EMPTY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used       <= '0;
            r_head       <= '0;
            r_idx        <= '0;
            r_rd_vld     <= 1'b0;
            r_abv_found  <= 1'b0;
            r_low_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_rd_vld  <= i_cmd.issue;
            r_out_vld <= i_cmd.commit;
            if (i_cmd.load) begin
                r_idx        <= '0;
                r_abv_found  <= 1'b0;
                r_low_found  <= 1'b0;
                r_free_found <= 1'b0;
            end else if (i_cmd.issue) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_rd_vld && (r_kind == KIND_DISPATCH)) begin
                if (w_pick_above) begin
                    r_abv_found <= 1'b1;
                end
                if (w_pick_low) begin
                    r_low_found <= 1'b1;
                end
            end
            if (r_rd_vld && (r_kind == KIND_ADD) && !r_rd_used) begin
                r_free_found <= 1'b1;
            end
            if (i_cmd.commit) begin
                if (r_kind == KIND_ADD) begin
                    if (r_free_found) begin
                        r_used[r_free_idx] <= 1'b1;
                    end
                end else if (r_low_found) begin
                    r_used[w_pick_idx] <= 1'b0;
                    r_head             <= w_pick_pos;
                end
            end
        end
    end

    assign o_done            = r_out_vld;
    assign o_status          = r_status;
    assign o_served_position = r_out_pos;
    assign o_served_write    = r_out_wr;

endmodule

[sv/clook_request_scheduler_top.sv]
// ----------------------------------------------------------------------------
// clook_request_scheduler_top
// c-look request queue: add requests, dispatch them in c-look order
// ----------------------------------------------------------------------------
// usage
//   command channel: an item is taken on a rising edge with start high and
//   busy low. i_kind selects add (store i_position / i_is_write in the
//   lowest free slot) or dispatch (remove the pending request nearest above
//   the last dispatched position, wrapping to the lowest one).
//   result channel: exactly one result per item, shown for one cycle with
//   o_done high; o_status gives added, full, dispatched or empty.
//   the result is on the ports in a cycle in which busy is already low, so
//   the next item can be taken then; no new item is taken before the result
//   of the last one. the slot scan reads one slot of the single-port slot
//   store per cycle, followed by a read stage, a compare drain and commit.
//   reset (i_rst_n low, synchronous) empties the queue and sets the last
//   dispatched position to zero; no clearing pass is needed.
//   the receiver cannot stall: each result must be taken in its cycle.
// ----------------------------------------------------------------------------
module clook_request_scheduler_top import clook_pkg::*; #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int POSITION_BITS = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic                  i_kind,
    input  logic [POS_PORT_W-1:0] i_position,
    input  logic                  i_is_write,
    output logic                  busy,
    output logic                  o_done,
    output logic [1:0]            o_status,
    output logic [POS_PORT_W-1:0] o_served_position,
    output logic                  o_served_write
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    clook_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .busy    (busy)
    );

    clook_dp #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .POSITION_BITS (POSITION_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_kind            (i_kind),
        .i_position        (i_position),
        .i_is_write        (i_is_write),
        .o_done            (o_done),
        .o_status          (o_status),
        .o_served_position (o_served_position),
        .o_served_write    (o_served_write)
    );

endmodule

[sv/clook_checker.sv]
// ----------------------------------------------------------------------------
// clook_checker
// port-level checks on the command and result channels
// ----------------------------------------------------------------------------
module clook_checker import clook_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  o_done,
    input logic [1:0]            o_status,
    input logic [POS_PORT_W-1:0] o_served_position,
    input logic                  o_served_write
);

    // an accepted item keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // a result only follows a busy period
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result without an item in progress");

    // result shows while the command side is free again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while still busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held over two cycles");

    // only a dispatch carries a served request
    a_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != ST_SERVED)) |->
            ((o_served_position == '0) && !o_served_write))
        else $error("non-dispatch result carries a request");

endmodule

bind clook_request_scheduler_top clook_checker u_chk (.*);

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the c-look request scheduler: a shadow queue
// predicts the status and served request of every item, and each result is
// checked field by field against the oldest outstanding prediction
// ----------------------------------------------------------------------------
module tb_top;
    import clook_pkg::*;

    localparam int DEPTH       = 16;
    localparam int RANDOM_CNT  = 1750;
    localparam int DRAIN_LIMIT = 400;
    localparam logic [POS_PORT_W-1:0] POS_MAX = '1;

    typedef struct packed {
        logic [1:0]            status;
        logic [POS_PORT_W-1:0] position;
        logic                  write;
    } t_outcome;

    // shadow of the request queue and the outcomes still to come out
    class clook_scoreboard;
        bit                    used[DEPTH];
        logic [POS_PORT_W-1:0] slot_pos[DEPTH];
        bit                    slot_wr[DEPTH];
        logic [POS_PORT_W-1:0] head;
        t_outcome              awaited[$];
        int                    failures;

        function new();
            foreach (used[i]) used[i] = 1'b0;
            head     = '0;
            failures = 0;
        endfunction

        // c-look choice: nearest strictly above the head, else the lowest
        function int next_in_sweep();
            int above;
            int lowest;
            above  = -1;
            lowest = -1;
            for (int i = 0; i < DEPTH; i++) begin
                if (!used[i]) continue;
                if (lowest < 0 || slot_pos[i] < slot_pos[lowest]) lowest = i;
                if (slot_pos[i] > head && (above < 0 || slot_pos[i] < slot_pos[above]))
                    above = i;
            end
            return (above >= 0) ? above : lowest;
        endfunction

        function void note_request(logic kind, logic [POS_PORT_W-1:0] pos, logic wr);
            t_outcome o;
            int       slot;
            o    = '0;
            slot = -1;
            if (kind == KIND_ADD) begin
                for (int i = 0; i < DEPTH; i++) begin
                    if (!used[i]) begin
                        slot = i;
                        break;
                    end
                end
                if (slot < 0) begin
                    o.status = ST_FULL;
                end else begin
                    used[slot]     = 1'b1;
                    slot_pos[slot] = pos;
                    slot_wr[slot]  = wr;
                    o.status       = ST_ADDED;
                end
            end else begin
                slot = next_in_sweep();
                if (slot < 0) begin
                    o.status = ST_EMPTY;
                end else begin
                    used[slot] = 1'b0;
                    head       = slot_pos[slot];
                    o.status   = ST_SERVED;
                    o.position = slot_pos[slot];
                    o.write    = slot_wr[slot];
                end
            end
            awaited.push_back(o);
        endfunction

        function void check_outcome(logic [1:0] status, logic [POS_PORT_W-1:0] pos,
                                    logic wr);
            t_outcome want;
            if (awaited.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: result with nothing pending: status %0d pos %h wr %b",
                             $time, status, pos, wr);
                return;
            end
            want = awaited.pop_front();
            if (status !== want.status || pos !== want.position || wr !== want.write) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: mismatch: want status %0d pos %h wr %b, got %0d %h %b",
                             $time, want.status, want.position, want.write,
                             status, pos, wr);
            end
        endfunction
    endclass

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  start      = 1'b0;
    logic                  i_kind     = 1'b0;
    logic [POS_PORT_W-1:0] i_position = '0;
    logic                  i_is_write = 1'b0;
    logic                  busy;
    logic                  o_done;
    logic [1:0]            o_status;
    logic [POS_PORT_W-1:0] o_served_position;
    logic                  o_served_write;

    clook_scoreboard tracker = new();
    bit              no_idle;

    always #6 i_clk = ~i_clk;

    clook_request_scheduler_top #(
        .QUEUE_DEPTH  (DEPTH),
        .POSITION_BITS(POS_PORT_W)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .i_kind           (i_kind),
        .i_position       (i_position),
        .i_is_write       (i_is_write),
        .busy             (busy),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_served_position(o_served_position),
        .o_served_write   (o_served_write)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1)
            tracker.check_outcome(o_status, o_served_position, o_served_write);
    end

    // hold start high across back-to-back items, drop it only for a real gap
    task automatic send_item(logic kind, logic [POS_PORT_W-1:0] pos, logic wr);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_kind     <= kind;
        i_position <= pos;
        i_is_write <= wr;
        do @(posedge i_clk); while (busy !== 1'b0);
        tracker.note_request(kind, pos, wr);
    endtask

    function automatic logic [POS_PORT_W-1:0] draw_position();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0:       return POS_PORT_W'($urandom_range(0, 31));
            1:       return POS_MAX - POS_PORT_W'($urandom_range(0, 7));
            2:       return tracker.head + POS_PORT_W'($urandom_range(0, 2)) - 1'b1;
            3:       return {r[15:0], 32'($urandom_range(0, 63))};
            default: return r[POS_PORT_W-1:0];
        endcase
    endfunction

    initial begin
        int add_pct;
        int waited;
        no_idle = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty queue, extremes, duplicates, wrap-around, full queue
        send_item(KIND_DISPATCH, POS_MAX, 1'b1);
        send_item(KIND_ADD, '0, 1'b0);
        send_item(KIND_ADD, POS_MAX, 1'b1);
        send_item(KIND_ADD, 48'd5, 1'b1);
        send_item(KIND_ADD, 48'd5, 1'b0);
        repeat (4) send_item(KIND_DISPATCH, '0, 1'b0);
        send_item(KIND_DISPATCH, '0, 1'b0);
        for (int i = 0; i < DEPTH; i++)
            send_item(KIND_ADD, POS_PORT_W'(DEPTH - 1 - i) * 48'h1000_0000_0001, i[0]);
        send_item(KIND_ADD, 48'h5555_5555_5555, 1'b1);
        send_item(KIND_DISPATCH, '0, 1'b0);

        // random bursts with a drifting add/dispatch mix so the queue swings
        // between empty and full
        add_pct = 50;
        for (int n = 0; n < RANDOM_CNT; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0:       add_pct = 25;
                    1:       add_pct = 75;
                    default: add_pct = 50;
                endcase
                no_idle = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(1, 100) <= add_pct)
                send_item(KIND_ADD, draw_position(), 1'($urandom));
            else
                send_item(KIND_DISPATCH, draw_position(), 1'($urandom));
        end
        start <= 1'b0;

        waited = 0;
        while (tracker.awaited.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DEPTH + 8) @(posedge i_clk);

        if (tracker.awaited.size() != 0) begin
            $display("%0d results never arrived", tracker.awaited.size());
            tracker.failures += tracker.awaited.size();
        end
        if (tracker.failures == 0) begin
            $display("** clook_request_scheduler_top: PASSED **");
        end else begin
            $display("** clook_request_scheduler_top: FAILED **");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("** clook_request_scheduler_top: FAILED **");
        $finish;
    end

endmodule

[files.f]
sv/clook_pkg.sv
sv/clook_ctrl.sv
sv/clook_dp.sv
sv/clook_request_scheduler_top.sv
sv/clook_checker.sv
sim/tb_top.sv
